// ===== rtl/csc_pkg.sv =====
// shared types, constants and arctangent table for the cordic sine/cosine core
package csc_pkg;

   // field widths
   localparam int AngleW = 18;
   localparam int AccW   = 19;
   localparam int RotW   = 20;
   localparam int OutW   = 18;
   localparam int ShiftW = 4;
   localparam int AtanW  = 17;

   // rotation steps after the initial 45-degree step (at most 15, table has 16 entries)
   localparam int Iterations = 16;
   localparam int NumSteps   = Iterations - 1;

   // gain constant in q16
   localparam logic signed [RotW-1:0] GainQ16 = 20'sd39797;

   // saturation limits for the result fields
   localparam logic signed [RotW-1:0] SatMax = 20'sd131071;
   localparam logic signed [RotW-1:0] SatMin = -20'sd131072;

   // one item as it travels down the rotation pipeline
   typedef struct packed {
      logic signed [AngleW-1:0] angle;
      logic signed [AccW-1:0]   acc;
      logic signed [RotW-1:0]   cos_v;
      logic signed [RotW-1:0]   sin_v;
   } rot_type;

   // atan(2^-i) in q16
   function automatic logic [AtanW-1:0] atan_q16(input logic [ShiftW-1:0] idx);
      logic [AtanW-1:0] val;
      case (idx)
         4'd0:    val = 17'd51472;
         4'd1:    val = 17'd30386;
         4'd2:    val = 17'd16055;
         4'd3:    val = 17'd8150;
         4'd4:    val = 17'd4091;
         4'd5:    val = 17'd2047;
         4'd6:    val = 17'd1024;
         4'd7:    val = 17'd512;
         4'd8:    val = 17'd256;
         4'd9:    val = 17'd128;
         4'd10:   val = 17'd64;
         4'd11:   val = 17'd32;
         4'd12:   val = 17'd16;
         4'd13:   val = 17'd8;
         4'd14:   val = 17'd4;
         default: val = 17'd2;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/cordic_sine_cosine_core.sv =====
// cordic sine/cosine core: start stage, rotation pipeline and saturating output
//
// Usage: each req_ beat carries one signed q16 angle (req_angle_q16), meant to lie
// within +-pi/2. Each rsp_ beat returns its sine and cosine in signed q16
// (rsp_sine_q16, rsp_cosine_q16), saturated to the 18-bit range, in input order.
// Both channels are valid/ready; a beat moves when valid and ready are high at
// a rising clock edge.
// From req_ beat to rsp_valid a beat passes one start register, one
// register per rotation step (15 steps) and one saturation/output register.
// Throughput is one angle per cycle while rsp_ready holds high (unrolled pipeline).
// Every stage has its own valid bit and moves when empty or when the stage
// after it moves, so bubbles close up. When the receiver holds rsp_ready low
// the pipeline fills up; req_ready drops only when every stage holds a beat.
// Nothing is lost or repeated during a stall.
// Reset (synchronous, active high) clears all valid bits; no item in flight
// survives it. The core keeps no state between items.
module cordic_sine_cosine_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [csc_pkg::AngleW-1:0]   req_angle_q16,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [csc_pkg::OutW-1:0]     rsp_sine_q16,
   output logic signed [csc_pkg::OutW-1:0]     rsp_cosine_q16
);

   logic                               stg_valid [0:csc_pkg::NumSteps];
   logic                               stg_ready [0:csc_pkg::NumSteps];
   csc_pkg::rot_type                   stg_data  [0:csc_pkg::NumSteps];

   logic                               start_valid_ff;
   csc_pkg::rot_type                   start_data_ff;
   csc_pkg::rot_type                   start_data_in;
   logic signed [csc_pkg::AccW-1:0]    atan0;

   logic                               out_valid_ff;
   logic                               out_ready;
   logic signed [csc_pkg::OutW-1:0]    sine_ff;
   logic signed [csc_pkg::OutW-1:0]    sine_in;
   logic signed [csc_pkg::OutW-1:0]    cosine_ff;
   logic signed [csc_pkg::OutW-1:0]    cosine_in;

   // start stage: first 45-degree rotation picked by the angle sign
   assign req_ready = !start_valid_ff || stg_ready[0];

   always_comb begin
      atan0               = $signed({2'b00, csc_pkg::atan_q16(csc_pkg::ShiftW'(0))});
      start_data_in.angle = req_angle_q16;
      start_data_in.cos_v = csc_pkg::GainQ16;
      if (req_angle_q16 <= 0) begin
         start_data_in.sin_v = -csc_pkg::GainQ16;
         start_data_in.acc   = -atan0;
      end else begin
         start_data_in.sin_v = csc_pkg::GainQ16;
         start_data_in.acc   = atan0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_valid_ff <= 1'b0;
      end else if (req_ready) begin
         start_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         start_data_ff <= start_data_in;
      end
   end

   assign stg_valid[0] = start_valid_ff;
   assign stg_data[0]  = start_data_ff;

   // rotation steps 1 .. NumSteps
   for (genvar k = 0; k < csc_pkg::NumSteps; k++) begin : g_step
      csc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .shift_idx (csc_pkg::ShiftW'(k + 1)),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_data   (stg_data[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_data  (stg_data[k+1])
      );
   end

   // output stage with saturation
   assign out_ready                    = !out_valid_ff || rsp_ready;
   assign stg_ready[csc_pkg::NumSteps] = out_ready;

   always_comb begin
      if (stg_data[csc_pkg::NumSteps].sin_v > csc_pkg::SatMax) begin
         sine_in = csc_pkg::SatMax[csc_pkg::OutW-1:0];
      end else if (stg_data[csc_pkg::NumSteps].sin_v < csc_pkg::SatMin) begin
         sine_in = csc_pkg::SatMin[csc_pkg::OutW-1:0];
      end else begin
         sine_in = stg_data[csc_pkg::NumSteps].sin_v[csc_pkg::OutW-1:0];
      end
      if (stg_data[csc_pkg::NumSteps].cos_v > csc_pkg::SatMax) begin
         cosine_in = csc_pkg::SatMax[csc_pkg::OutW-1:0];
      end else if (stg_data[csc_pkg::NumSteps].cos_v < csc_pkg::SatMin) begin
         cosine_in = csc_pkg::SatMin[csc_pkg::OutW-1:0];
      end else begin
         cosine_in = stg_data[csc_pkg::NumSteps].cos_v[csc_pkg::OutW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= stg_valid[csc_pkg::NumSteps];
      end
      if (stg_valid[csc_pkg::NumSteps] && out_ready) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sine_q16   = sine_ff;
   assign rsp_cosine_q16 = cosine_ff;

endmodule

// ===== rtl/csc_stage.sv =====
// one registered cordic rotation step with its own valid bit and ready
module csc_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [csc_pkg::ShiftW-1:0]      shift_idx,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  csc_pkg::rot_type                in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output csc_pkg::rot_type                out_data
);

   logic                            valid_ff;
   csc_pkg::rot_type                data_ff;
   csc_pkg::rot_type                data_in;

   logic signed [csc_pkg::AccW-1:0] angle_ext;
   logic signed [csc_pkg::AccW-1:0] acc_cur;
   logic signed [csc_pkg::AccW-1:0] atan_ext;
   logic signed [csc_pkg::RotW-1:0] cos_cur;
   logic signed [csc_pkg::RotW-1:0] sin_cur;
   logic signed [csc_pkg::RotW-1:0] cos_sh;
   logic signed [csc_pkg::RotW-1:0] sin_sh;
   logic                            rot_up;

   // stage moves when empty or when the next one takes its beat
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // rotation direction and cross terms
   always_comb begin
      angle_ext = {in_data.angle[csc_pkg::AngleW-1], in_data.angle};
      acc_cur   = in_data.acc;
      cos_cur   = in_data.cos_v;
      sin_cur   = in_data.sin_v;
      atan_ext  = $signed({2'b00, csc_pkg::atan_q16(shift_idx)});
      cos_sh    = cos_cur >>> shift_idx;
      sin_sh    = sin_cur >>> shift_idx;
      rot_up    = acc_cur < angle_ext;

      data_in.angle = in_data.angle;
      if (rot_up) begin
         data_in.acc   = acc_cur + atan_ext;
         data_in.cos_v = cos_cur - sin_sh;
         data_in.sin_v = sin_cur + cos_sh;
      end else begin
         data_in.acc   = acc_cur - atan_ext;
         data_in.cos_v = cos_cur + sin_sh;
         data_in.sin_v = sin_cur - cos_sh;
      end
   end

   // valid bit and payload register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== dv/tb_cordic_sine_cosine_core.sv =====
// self-checking testbench for the cordic sine/cosine core
`timescale 1ns / 1ps

module tb_cordic_sine_cosine_core;

   // rotation constants held independently of the design
   localparam int RotGain      = 39797;
   localparam int OutMax       = 131071;
   localparam int OutMin       = -131072;
   localparam int AtanEntries  = 16;
   localparam int ArctanQ16 [AtanEntries] = '{
      51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };
   localparam int HalfPi       = 102944;

   // run shape
   localparam int RandomAngles   = 825;
   localparam int HoldAngles     = 100;
   localparam int RspHoldCycles  = 120;
   localparam int WatchdogLimit  = 2000;
   localparam int SettleCycles   = 40;

   // hand-picked angles: zero, unit steps, the half-pi edges, the first 45-degree
   // step, the convergence limit and the full 18-bit extremes
   localparam int DirectedAngles [25] = '{
      0, 1, -1, 2, -2, HalfPi, -HalfPi, HalfPi - 1, -HalfPi + 1,
      51472, -51472, 51471, 51473, 25736, -25736,
      131071, -131072, HalfPi + 1, -HalfPi - 1, 114000, -114000,
      65536, -65536, 21846, 100
   };
   localparam int NearEdgeAngles [11] = '{
      0, 1, -1, HalfPi, -HalfPi, 51472, -51472, 131071, -131072, HalfPi + 1, -HalfPi - 1
   };

   // receiver stall patterns
   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   typedef struct packed {
      logic signed [csc_pkg::AngleW-1:0] angle;
      logic signed [csc_pkg::OutW-1:0]   sine;
      logic signed [csc_pkg::OutW-1:0]   cosine;
   } trig_pair_type;

   // expected sine/cosine store with its own rotation predictor
   class sine_cosine_scoreboard;
      trig_pair_type expected_q[$];
      int mismatches;
      int angles_seen;
      int beyond_half_pi;
      int results_checked;

      function new();
         mismatches      = 0;
         angles_seen     = 0;
         beyond_half_pi  = 0;
         results_checked = 0;
      endfunction

      function logic signed [csc_pkg::OutW-1:0] clamp_out(int v);
         int clamped;
         clamped = v;
         if (v > OutMax) clamped = OutMax;
         if (v < OutMin) clamped = OutMin;
         return clamped[csc_pkg::OutW-1:0];
      endfunction

      // cordic rotation: first 45-degree step folded into the start value
      function trig_pair_type rotate(logic signed [csc_pkg::AngleW-1:0] angle);
         int target;
         int cos_acc;
         int sin_acc;
         int phase;
         int cos_prev;
         int sin_prev;
         int step;
         trig_pair_type res;
         target  = angle;
         cos_acc = RotGain;
         if (target <= 0) begin
            sin_acc = -RotGain;
            phase   = -ArctanQ16[0];
         end else begin
            sin_acc = RotGain;
            phase   = ArctanQ16[0];
         end
         for (step = 1; step < csc_pkg::Iterations && step < AtanEntries; step++) begin
            cos_prev = cos_acc;
            sin_prev = sin_acc;
            if (phase < target) begin
               phase  += ArctanQ16[step];
               cos_acc = cos_prev - (sin_prev >>> step);
               sin_acc = sin_prev + (cos_prev >>> step);
            end else begin
               phase  -= ArctanQ16[step];
               cos_acc = cos_prev + (sin_prev >>> step);
               sin_acc = sin_prev - (cos_prev >>> step);
            end
         end
         res.angle  = angle;
         res.sine   = clamp_out(sin_acc);
         res.cosine = clamp_out(cos_acc);
         return res;
      endfunction

      function void note_angle(logic signed [csc_pkg::AngleW-1:0] angle);
         angles_seen++;
         if (angle > HalfPi || angle < -HalfPi) beyond_half_pi++;
         expected_q.push_back(rotate(angle));
      endfunction

      function void check_result(logic signed [csc_pkg::OutW-1:0] sine,
                                 logic signed [csc_pkg::OutW-1:0] cosine);
         trig_pair_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with no angle outstanding: sine %0d cosine %0d", sine, cosine);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (sine !== want.sine) begin
            $error("sine_q16 mismatch for angle %0d: expected %0d, actual %0d",
                   want.angle, want.sine, sine);
            mismatches++;
         end
         if (cosine !== want.cosine) begin
            $error("cosine_q16 mismatch for angle %0d: expected %0d, actual %0d",
                   want.angle, want.cosine, cosine);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [csc_pkg::AngleW-1:0]   req_angle_q16 = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [csc_pkg::OutW-1:0]     rsp_sine_q16;
   logic signed [csc_pkg::OutW-1:0]     rsp_cosine_q16;

   bit hold_rsp_request = 1'b0;
   int rsp_holds_done = 0;

   sine_cosine_scoreboard sb = new();

   cordic_sine_cosine_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_angle_q16  (req_angle_q16),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sine_q16   (rsp_sine_q16),
      .rsp_cosine_q16 (rsp_cosine_q16)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // beat monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_angle(req_angle_q16);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_sine_q16, rsp_cosine_q16);
      end
   end

   // watchdog on cycles with no beat moving
   initial begin : accept_watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= WatchdogLimit) begin
            $error("no beat moved for %0d cycles, %0d results outstanding",
                   quiet, sb.pending());
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver: changing stall patterns plus long hold-offs on request
   initial begin : rsp_ready_pattern
      stall_mode_type mode;
      int mode_left;
      int tick;
      mode      = STALL_NONE;
      mode_left = 0;
      tick      = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RspHoldCycles) @(posedge clock);
            rsp_holds_done++;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(STALL_NONE, STALL_HEAVY));
            mode_left = $urandom_range(16, 160);
         end
         mode_left--;
         tick++;
         case (mode)
            STALL_NONE: begin
               rsp_ready <= 1'b1;
            end
            STALL_RANDOM: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            STALL_PERIODIC: begin
               rsp_ready <= (tick % 5) != 0;
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 7) == 0);
            end
         endcase
         @(posedge clock);
      end
   end

   // offer one angle and hold it until the beat moves
   task automatic send_angle(input logic signed [csc_pkg::AngleW-1:0] angle);
      req_valid     <= 1'b1;
      req_angle_q16 <= angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // mostly legal angles, some full-range words, some near the edges
   function automatic logic signed [csc_pkg::AngleW-1:0] pick_angle();
      int sel;
      int base;
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
         base = int'($urandom_range(0, 2 * HalfPi)) - HalfPi;
      end else if (sel < 92) begin
         base = int'($urandom());
      end else begin
         base = NearEdgeAngles[$urandom_range(0, 10)] + int'($urandom_range(0, 4)) - 2;
      end
      return base[csc_pkg::AngleW-1:0];
   endfunction

   // stimulus sequence
   initial begin : angle_sequence
      int sent;
      int burst;
      int bursts;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed corners, back to back
      foreach (DirectedAngles[k]) send_angle(DirectedAngles[k][csc_pkg::AngleW-1:0]);
      wait_drained();

      // long receiver hold-off while the sender keeps pushing
      hold_rsp_request = 1'b1;
      repeat (HoldAngles) send_angle(pick_angle());
      wait_drained();

      // random bursts with random gaps
      sent   = 0;
      bursts = 0;
      while (sent < RandomAngles) begin
         burst = $urandom_range(1, 40);
         repeat (burst) send_angle(pick_angle());
         sent += burst;
         bursts++;
         if (bursts % 9 == 0) wait_drained();
         else if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 20));
      end

      wait_drained();
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d angles (%0d beyond +-pi/2), %0d results checked",
               sb.angles_seen, sb.beyond_half_pi, sb.results_checked);
      $display("receiver held off %0d times, %0d field mismatches",
               rsp_holds_done, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
